/* src/adsr_pkg.sv */
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types and constants for the linear ADSR envelope generator.
// ----------------------------------------------------------------------------
package adsr_pkg;

    // Width of every configuration register and of each level field
    localparam int REG_W     = 25;
    localparam int CFG_IDX_W = 2;
    localparam int LANES_MAX = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 2'd3;

    // Envelope phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_ATTACK  = 5'b00010,
        PH_DECAY   = 5'b00100,
        PH_SUSTAIN = 5'b01000,
        PH_RELEASE = 5'b10000
    } phase_t;

    // Envelope settings shared by all lanes
    typedef struct packed {
        logic [REG_W-1:0] attack_step;
        logic [REG_W-1:0] decay_step;
        logic [REG_W-1:0] release_step;
        logic [REG_W-1:0] sustain_level;
    } env_cfg_t;

endpackage

/* src/adsr_envelope_generator_unit.sv */
// ----------------------------------------------------------------------------
// adsr_envelope_generator_unit
// Eight-lane linear ADSR envelope generator, one sample tick per request.
//
//   Channel   Handshake             Payload
//   in        in_valid / in_ready   gate_bits
//   out       out_valid / out_ready level_0 .. level_7
//   cfg       cfg_write             cfg_index, cfg_data
//
// Each request is processed combinationally: lane update from the lane state
// registers straight into the result register. One request per cycle is
// sustained unless out_ready stalls it. The input is stalled only while a result
// waits in the result register and the consumer holds out_ready low.
// Reset clears all lanes to idle at level zero and loads default settings.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_unit
    import adsr_pkg::*;
#(
    parameter int LANES         = 8,
    parameter int FRACTION_BITS = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           gate_bits,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [REG_W-1:0]     level_0,
    output logic [REG_W-1:0]     level_1,
    output logic [REG_W-1:0]     level_2,
    output logic [REG_W-1:0]     level_3,
    output logic [REG_W-1:0]     level_4,
    output logic [REG_W-1:0]     level_5,
    output logic [REG_W-1:0]     level_6,
    output logic [REG_W-1:0]     level_7,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    localparam logic [63:0]      ONE_FULL   = 64'd1 << FRACTION_BITS;
    localparam logic [REG_W-1:0] STEP_RESET = ONE_FULL[REG_W-1:0];

    env_cfg_t         cfg_reg;
    logic             out_valid_reg;
    logic [REG_W-1:0] level_reg [LANES_MAX];
    logic [REG_W-1:0] lane_level [LANES_MAX];
    logic             accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Hold the envelope settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_step   <= STEP_RESET;
            cfg_reg.decay_step    <= STEP_RESET;
            cfg_reg.release_step  <= STEP_RESET;
            cfg_reg.sustain_level <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ATTACK_STEP:   cfg_reg.attack_step   <= cfg_data;
                CFG_DECAY_STEP:    cfg_reg.decay_step    <= cfg_data;
                CFG_RELEASE_STEP:  cfg_reg.release_step  <= cfg_data;
                CFG_SUSTAIN_LEVEL: cfg_reg.sustain_level <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Build active lanes; drive unused lanes to zero
    genvar g;
    generate
        for (g = 0; g < LANES_MAX; g++)
        begin : g_lane
            if (g < LANES)
            begin : g_used
                adsr_lane #(
                    .FRACTION_BITS(FRACTION_BITS)
                ) u_lane (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .advance (accept),
                    .gate    (gate_bits[g]),
                    .cfg     (cfg_reg),
                    .level   (lane_level[g])
                );
            end
            else
            begin : g_unused
                assign lane_level[g] = '0;
            end
        end
    endgenerate

    // Track result occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Capture the levels of each accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < LANES_MAX; i++)
                level_reg[i] <= lane_level[i];
        end
    end

    assign level_0 = level_reg[0];
    assign level_1 = level_reg[1];
    assign level_2 = level_reg[2];
    assign level_3 = level_reg[3];
    assign level_4 = level_reg[4];
    assign level_5 = level_reg[5];
    assign level_6 = level_reg[6];
    assign level_7 = level_reg[7];

endmodule

/* src/adsr_lane.sv */
// ----------------------------------------------------------------------------
// adsr_lane
// One envelope lane: phase, level and previous gate, with the per-tick
// edge handling, phase transition, step and clamp.
// ----------------------------------------------------------------------------
module adsr_lane
    import adsr_pkg::*;
#(
    parameter int FRACTION_BITS = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             gate,
    input  env_cfg_t         cfg,
    output logic [REG_W-1:0] level
);

    localparam int LW = FRACTION_BITS + 1;
    localparam int CW = ((LW > REG_W) ? LW : REG_W) + 1;
    localparam logic [CW-1:0] ONE = CW'(1) << FRACTION_BITS;

    phase_t          phase_reg;
    phase_t          phase_next;
    phase_t          ph_edge;
    logic [LW-1:0]   level_reg;
    logic [LW-1:0]   level_next;
    logic            prior_reg;
    logic [CW-1:0]   lv_edge;
    logic [CW-1:0]   lv_step;
    logic [CW-1:0]   lv_clamp;

    // Apply gate edges, check the transition on the old level, then step
    always_comb
    begin
        ph_edge = phase_reg;
        lv_edge = CW'(level_reg);
        if (gate && !prior_reg)
        begin
            ph_edge = PH_ATTACK;
            lv_edge = '0;
        end
        else if (!gate && prior_reg)
        begin
            ph_edge = PH_RELEASE;
        end

        phase_next = ph_edge;
        case (ph_edge)
            PH_ATTACK:
            begin
                if (!(cfg.attack_step != '0 && lv_edge < ONE))
                    phase_next = PH_DECAY;
            end
            PH_DECAY:
            begin
                if (!(cfg.decay_step != '0 && lv_edge > CW'(cfg.sustain_level)))
                    phase_next = PH_SUSTAIN;
            end
            PH_RELEASE:
            begin
                if (!(cfg.release_step != '0 && lv_edge != '0))
                    phase_next = PH_IDLE;
            end
            default:
            begin
            end
        endcase

        lv_step = lv_edge;
        case (phase_next)
            PH_ATTACK:
                lv_step = lv_edge + CW'(cfg.attack_step);
            PH_DECAY:
                lv_step = (CW'(cfg.decay_step) >= lv_edge) ? '0
                                                           : lv_edge - CW'(cfg.decay_step);
            PH_RELEASE:
                lv_step = (CW'(cfg.release_step) >= lv_edge) ? '0
                                                             : lv_edge - CW'(cfg.release_step);
            default:
            begin
            end
        endcase

        lv_clamp   = (lv_step > ONE) ? ONE : lv_step;
        level_next = lv_clamp[LW-1:0];
    end

    assign level = lv_clamp[REG_W-1:0];

    // Advance the lane state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            level_reg <= '0;
            prior_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            level_reg <= level_next;
            prior_reg <= gate;
        end
    end

endmodule

/* src/adsr_checker.sv */
// ----------------------------------------------------------------------------
// adsr_checker
// Port-level checks for the envelope generator, bound to the top level.
// ----------------------------------------------------------------------------
module adsr_checker
    import adsr_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [REG_W-1:0]     level_0,
    input logic [REG_W-1:0]     level_1,
    input logic [REG_W-1:0]     level_2,
    input logic [REG_W-1:0]     level_3,
    input logic [REG_W-1:0]     level_4,
    input logic [REG_W-1:0]     level_5,
    input logic [REG_W-1:0]     level_6,
    input logic [REG_W-1:0]     level_7
);

    // Input is taken whenever the result slot is free or draining
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow result slot state");

    // Every accepted request yields a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted request produced no result");

    // No result appears without a request
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !(in_valid && in_ready)) |=> !out_valid)
        else $error("result appeared without a request");

    // A stalled result holds its levels
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(level_0)
            && $stable(level_1) && $stable(level_2) && $stable(level_3)
            && $stable(level_4) && $stable(level_5) && $stable(level_6)
            && $stable(level_7)))
        else $error("stalled result changed");

endmodule

bind adsr_envelope_generator_unit adsr_checker u_adsr_checker (.*);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the eight-lane ADSR envelope generator. Gate words
// go in through a bursty sender; level results come back through a receiver
// that stalls on its own pattern. A built-in envelope predictor tracks every
// lane and each result is checked lane by lane, across several settings.
// ----------------------------------------------------------------------------
module testbench;
    import adsr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [LANES_MAX-1:0][REG_W-1:0] level_vec_t;

    localparam logic [REG_W-1:0] ONE_Q    = 25'h1000000;
    localparam logic [REG_W-1:0] REG_MAX  = '1;
    localparam logic [REG_W:0]   UNITY    = 26'h1000000;
    localparam int               IDLE_CAP = 4000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [7:0]           gate_bits = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [REG_W-1:0]     level_0, level_1, level_2, level_3;
    logic [REG_W-1:0]     level_4, level_5, level_6, level_7;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data  = '0;

    // Pending gate requests and expected level vectors
    logic [7:0] gate_q [$];
    level_vec_t level_q [$];

    // Predicted envelope state and settings
    env_cfg_t         cur_cfg;
    phase_t           lane_ph   [LANES_MAX];
    logic [REG_W-1:0] lane_lvl  [LANES_MAX];
    logic             lane_gate [LANES_MAX];

    int err_count   = 0;
    int gap_left    = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stretch_left = 0;
    int idle_cycles = 0;

    adsr_envelope_generator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .gate_bits (gate_bits),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .level_0   (level_0),
        .level_1   (level_1),
        .level_2   (level_2),
        .level_3   (level_3),
        .level_4   (level_4),
        .level_5   (level_5),
        .level_6   (level_6),
        .level_7   (level_7),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        if (err_count < 50)
            $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Advance every lane by one tick and queue the expected level vector
    function automatic void advance_envelopes(input logic [7:0] gates);
        logic [REG_W:0] lvl;
        phase_t         ph;
        level_vec_t     res;
        for (int l = 0; l < LANES_MAX; l++)
        begin
            ph  = lane_ph[l];
            lvl = {1'b0, lane_lvl[l]};
            // force a phase on gate edges
            if (gates[l] && !lane_gate[l])
            begin
                ph  = PH_ATTACK;
                lvl = '0;
            end
            else if (!gates[l] && lane_gate[l])
                ph = PH_RELEASE;
            lane_gate[l] = gates[l];
            // check the transition on the old level
            case (ph)
                PH_ATTACK:
                    if (!(cur_cfg.attack_step != 0 && lvl < UNITY))
                        ph = PH_DECAY;
                PH_DECAY:
                    if (!(cur_cfg.decay_step != 0 && lvl > {1'b0, cur_cfg.sustain_level}))
                        ph = PH_SUSTAIN;
                PH_RELEASE:
                    if (!(cur_cfg.release_step != 0 && lvl != 0))
                        ph = PH_IDLE;
                default: ;
            endcase
            // step by the current phase, then clamp to one
            case (ph)
                PH_ATTACK:
                    lvl = lvl + {1'b0, cur_cfg.attack_step};
                PH_DECAY:
                    lvl = ({1'b0, cur_cfg.decay_step} >= lvl) ? '0
                          : lvl - {1'b0, cur_cfg.decay_step};
                PH_RELEASE:
                    lvl = ({1'b0, cur_cfg.release_step} >= lvl) ? '0
                          : lvl - {1'b0, cur_cfg.release_step};
                default: ;
            endcase
            if (lvl > UNITY)
                lvl = UNITY;
            lane_ph[l]  = ph;
            lane_lvl[l] = lvl[REG_W-1:0];
            res[l]      = lvl[REG_W-1:0];
        end
        level_q.push_back(res);
    endfunction

    // Write one register and mirror it into the predicted settings
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_ATTACK_STEP:   cur_cfg.attack_step   = val;
            CFG_DECAY_STEP:    cur_cfg.decay_step    = val;
            CFG_RELEASE_STEP:  cur_cfg.release_step  = val;
            CFG_SUSTAIN_LEVEL: cur_cfg.sustain_level = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_envelope(input logic [REG_W-1:0] atk, input logic [REG_W-1:0] dcy,
                                input logic [REG_W-1:0] rel, input logic [REG_W-1:0] sus);
        write_reg(CFG_ATTACK_STEP, atk);
        write_reg(CFG_DECAY_STEP, dcy);
        write_reg(CFG_RELEASE_STEP, rel);
        write_reg(CFG_SUSTAIN_LEVEL, sus);
    endtask

    // Hold until every request is taken and every result has come back
    task automatic drain();
        while (gate_q.size() != 0 || level_q.size() != 0)
            @(posedge clk);
    endtask

    // Pick a setting, weighted toward zero, one, full scale and slow ramps
    function automatic logic [REG_W-1:0] rand_setting();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ONE_Q;
            2: return REG_MAX;
            3: return REG_W'($urandom);
            default: return REG_W'(ONE_Q / $urandom_range(2, 48) + $urandom_range(0, 255));
        endcase
    endfunction

    // Sender: present queued gate words in bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive_gates
        logic fire;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            gate_bits <= '0;
        end
        else
        begin
            fire = in_valid && in_ready;
            if (fire)
            begin
                advance_envelopes(gate_bits);
                void'(gate_q.pop_front());
            end
            if (!in_valid || fire)
            begin
                if (gap_left > 0 || gate_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    in_valid  <= 1'b1;
                    gate_bits <= gate_q[0];
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Receiver: stall in stretches of changing style, check each result
    always @(posedge clk or negedge rst_n)
    begin : check_levels
        level_vec_t got;
        level_vec_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {level_7, level_6, level_5, level_4,
                       level_3, level_2, level_1, level_0};
                if (level_q.size() == 0)
                    flag_error("level result with nothing pending");
                else
                begin
                    want = level_q.pop_front();
                    for (int l = 0; l < LANES_MAX; l++)
                        if (got[l] !== want[l])
                            flag_error($sformatf("lane %0d level exp %h got %h",
                                                 l, want[l], got[l]));
                end
            end
            if (stretch_left == 0)
            begin
                stall_mode   = $urandom_range(0, 3);
                stretch_left = $urandom_range(10, 60);
            end
            else
                stretch_left--;
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= stretch_left[2];
            endcase
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_CAP)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] held;
        int         toggle_odds;

        cur_cfg.attack_step   = ONE_Q;
        cur_cfg.decay_step    = ONE_Q;
        cur_cfg.release_step  = ONE_Q;
        cur_cfg.sustain_level = '0;
        for (int l = 0; l < LANES_MAX; l++)
        begin
            lane_ph[l]   = PH_IDLE;
            lane_lvl[l]  = '0;
            lane_gate[l] = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: instant attack, decay to zero
        gate_q = '{8'h00, 8'hFF, 8'hFF, 8'h5A, 8'h00};
        drain();

        // slow ramps: fall in attack, retrigger, reach sustain, release
        set_envelope(ONE_Q / 4, ONE_Q / 8, ONE_Q / 4, ONE_Q / 2);
        gate_q = '{8'hFF, 8'hFF, 8'h0F, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
        drain();

        // oversized attack, zero decay, sustain above one
        set_envelope(REG_MAX, '0, REG_MAX, REG_MAX);
        gate_q = '{8'hFF, 8'hFF, 8'h00};
        drain();

        // zero attack and zero release steps
        set_envelope('0, ONE_Q, '0, '0);
        gate_q = '{8'hFF, 8'h00};
        drain();

        // random settings, mostly held gates with occasional toggles
        held = '0;
        for (int chunk = 0; chunk < 8; chunk++)
        begin
            set_envelope(rand_setting(), rand_setting(), rand_setting(), rand_setting());
            toggle_odds = $urandom_range(3, 40);
            for (int n = 0; n < 50; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    gate_q.push_back(8'($urandom));
                else
                begin
                    for (int l = 0; l < LANES_MAX; l++)
                        if ($urandom_range(0, toggle_odds - 1) == 0)
                            held[l] = ~held[l];
                    gate_q.push_back(held);
                end
            end
            drain();
        end

        repeat (4) @(posedge clk);
        if (err_count == 0 && level_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
